>>> rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg - shared types and constants of the line clipper
// Coordinate widths, payload structs, register indexes and the divider
// request/response bundles used by the clipper and its divider.
// ----------------------------------------------------------------------------
package csl_pkg;

    // Coordinate and datapath widths
    localparam int C_COORD_BITS = 12;
    localparam int C_DIFF_BITS  = C_COORD_BITS + 1;      // coordinate differences
    localparam int C_PROD_BITS  = 2 * C_DIFF_BITS;       // product of two differences
    localparam int C_NUM_BITS   = 2 * C_COORD_BITS + 2;  // 2|n| + |d|
    localparam int C_DEN_BITS   = C_COORD_BITS + 2;      // 2|d|
    localparam int C_QUOT_BITS  = C_COORD_BITS + 1;      // rounded quotient, <= 2^COORD_BITS
    localparam int C_MAX_MOVES  = 8;
    localparam int C_MOVE_BITS  = $clog2(C_MAX_MOVES + 1);

    typedef logic signed [C_COORD_BITS-1:0] t_coord;

    // Outcode bit positions
    localparam int C_OC_LEFT   = 3;
    localparam int C_OC_TOP    = 2;
    localparam int C_OC_RIGHT  = 1;
    localparam int C_OC_BOTTOM = 0;

    typedef logic [3:0] t_outcode;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CORNER_A_X = 2'd0,
        CFG_CORNER_A_Y = 2'd1,
        CFG_CORNER_B_X = 2'd2,
        CFG_CORNER_B_Y = 2'd3
    } t_cfg_idx;

    // Register reset values
    localparam t_coord C_RST_CORNER_A_X = t_coord'(0);
    localparam t_coord C_RST_CORNER_A_Y = t_coord'(0);
    localparam t_coord C_RST_CORNER_B_X = t_coord'(1079);
    localparam t_coord C_RST_CORNER_B_Y = t_coord'(719);

    // Segment in and clipped segment out
    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_seg_in;

    typedef struct packed {
        logic   visible;
        t_coord clip_start_x;
        t_coord clip_start_y;
        t_coord clip_end_x;
        t_coord clip_end_y;
    } t_seg_out;

    // Divider handshake
    typedef struct packed {
        logic                  start;
        logic [C_NUM_BITS-1:0] num;
        logic [C_DEN_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [C_QUOT_BITS-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/csl_div.sv
// ----------------------------------------------------------------------------
// csl_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle. The quotient is known to
// fit C_QUOT_BITS, so only that many steps run. Done pulses for one cycle
// and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module csl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csl_pkg::t_div_req i_req,
    output csl_pkg::t_div_rsp o_rsp
);
    import csl_pkg::*;

    localparam int C_CNT_BITS = $clog2(C_QUOT_BITS + 1);

    logic [C_NUM_BITS-1:0]  r_rem;
    logic [C_NUM_BITS-1:0]  r_dsh;
    logic [C_QUOT_BITS-1:0] r_q;
    logic [C_CNT_BITS-1:0]  r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic                   w_ge;

    // trial subtract against the shifted divisor
    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num;
                r_dsh  <= {i_req.den, {(C_QUOT_BITS-1){1'b0}}};
                r_q    <= '0;
                r_cnt  <= C_CNT_BITS'(C_QUOT_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[C_QUOT_BITS-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == C_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

>>> rtl/cohen_sutherland_line_clipper_unit.sv
// ----------------------------------------------------------------------------
// cohen_sutherland_line_clipper_unit - outcode line clipper
// Clips one segment against the window set by two corner registers, moving
// outside endpoints onto window edges until the segment is accepted or
// rejected. Crossing points use one multiply and a shared divider.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   cfg     | in        | i_cfg_valid/ready   | i_cfg_index, i_cfg_data
//   in      | in        | i_in_valid/stall    | i_in  (t_seg_in)
//   out     | out       | o_out_valid/stall   | o_out (t_seg_out)
//
// One segment at a time: o_in_stall is high from acceptance until the result
// is loaded into the output register. A trivial accept or reject goes from
// the outcode check straight to the result; each edge move steps through
// multiply, divide set-up, divide and fix-up, then the outcodes again.
// The output register lets a new segment in while a result waits on stall.
// Reset is synchronous, active low; corners reset to (0,0) and (1079,719).
// ----------------------------------------------------------------------------
module cohen_sutherland_line_clipper_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  csl_pkg::t_cfg_idx i_cfg_index,
    input  csl_pkg::t_coord   i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  csl_pkg::t_seg_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output csl_pkg::t_seg_out o_out
);
    import csl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CODE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

    typedef logic signed [C_DIFF_BITS-1:0]  t_diff;
    typedef logic signed [C_COORD_BITS+1:0] t_wide;

    // outcode of a point against the latched edges
    function automatic t_outcode f_outcode(t_coord x, t_coord y, t_coord l, t_coord r,
                                           t_coord b, t_coord t);
        t_outcode c;
        c              = '0;
        c[C_OC_LEFT]   = (x < l);
        c[C_OC_TOP]    = (y > t);
        c[C_OC_RIGHT]  = (x > r);
        c[C_OC_BOTTOM] = (y < b);
        return c;
    endfunction

    t_state   r_state;
    t_coord   r_ca_x, r_ca_y, r_cb_x, r_cb_y;
    t_coord   r_left, r_right, r_bot, r_top;
    t_coord   r_x0, r_y0, r_x1, r_y1;
    t_coord   r_px0, r_py0, r_px1, r_py1;
    logic [C_MOVE_BITS-1:0] r_moves;
    logic     r_vis;
    logic     r_sel;
    logic     r_xedge;
    t_coord   r_edge;
    t_diff    r_fa, r_fb, r_dv;
    logic signed [C_PROD_BITS-1:0] r_prod;
    logic     r_neg;
    logic     r_out_valid;
    t_seg_out r_out;

    t_diff    w_ddx, w_ddy;
    t_outcode w_c0, w_c1, w_code;
    logic     w_sel, w_xedge;
    t_coord   w_edge;
    t_diff    w_fa, w_fb, w_dv;
    logic [C_PROD_BITS-1:0] w_prod_abs;
    logic [C_DIFF_BITS-1:0] w_dv_abs;
    t_wide    w_qs, w_qadj, w_base, w_new;
    t_coord   w_new_c;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // shared divider
    csl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // original slope terms
    assign w_ddx = t_diff'(r_x1) - t_diff'(r_x0);
    assign w_ddy = t_diff'(r_y1) - t_diff'(r_y0);

    // outcodes and edge choice: start point first, left/top/right/bottom
    assign w_c0   = f_outcode(r_px0, r_py0, r_left, r_right, r_bot, r_top);
    assign w_c1   = f_outcode(r_px1, r_py1, r_left, r_right, r_bot, r_top);
    assign w_sel  = (w_c0 == '0);
    assign w_code = w_sel ? w_c1 : w_c0;

    always_comb begin
        w_xedge = 1'b0;
        w_edge  = r_bot;
        if (w_code[C_OC_LEFT]) begin
            w_xedge = 1'b1;
            w_edge  = r_left;
        end else if (w_code[C_OC_TOP]) begin
            w_edge  = r_top;
        end else if (w_code[C_OC_RIGHT]) begin
            w_xedge = 1'b1;
            w_edge  = r_right;
        end
    end

    assign w_fa = w_xedge ? (t_diff'(w_edge) - t_diff'(r_x0)) : (t_diff'(w_edge) - t_diff'(r_y0));
    assign w_fb = w_xedge ? w_ddy : w_ddx;
    assign w_dv = w_xedge ? w_ddx : w_ddy;

    // rounding division set-up: q = (2|n| + |d|) / (2|d|)
    assign w_prod_abs = r_prod[C_PROD_BITS-1] ? C_PROD_BITS'(-r_prod) : C_PROD_BITS'(r_prod);
    assign w_dv_abs   = r_dv[C_DIFF_BITS-1] ? C_DIFF_BITS'(-r_dv) : C_DIFF_BITS'(r_dv);

    assign w_div_req.start = (r_state == S_PREP);
    assign w_div_req.num   = (C_NUM_BITS'(w_prod_abs) << 1) + C_NUM_BITS'(w_dv_abs);
    assign w_div_req.den   = {w_dv_abs, 1'b0};

    // new coordinate on the crossing edge
    assign w_qs    = t_wide'({1'b0, w_div_rsp.quot});
    assign w_qadj  = r_neg ? -w_qs : w_qs;
    assign w_base  = r_xedge ? t_wide'(r_y0) : t_wide'(r_x0);
    assign w_new   = w_base + w_qadj;
    assign w_new_c = w_new[C_COORD_BITS-1:0];

    // sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ca_x      <= C_RST_CORNER_A_X;
            r_ca_y      <= C_RST_CORNER_A_Y;
            r_cb_x      <= C_RST_CORNER_B_X;
            r_cb_y      <= C_RST_CORNER_B_Y;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CORNER_A_X: r_ca_x <= i_cfg_data;
                    CFG_CORNER_A_Y: r_ca_y <= i_cfg_data;
                    CFG_CORNER_B_X: r_cb_x <= i_cfg_data;
                    CFG_CORNER_B_Y: r_cb_y <= i_cfg_data;
                    default: ;
                endcase
            end

            // result taken: free the output register unless a new one loads now
            if (!i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x0    <= i_in.start_x;
                        r_y0    <= i_in.start_y;
                        r_x1    <= i_in.end_x;
                        r_y1    <= i_in.end_y;
                        r_px0   <= i_in.start_x;
                        r_py0   <= i_in.start_y;
                        r_px1   <= i_in.end_x;
                        r_py1   <= i_in.end_y;
                        r_left  <= (r_ca_x < r_cb_x) ? r_ca_x : r_cb_x;
                        r_right <= (r_ca_x < r_cb_x) ? r_cb_x : r_ca_x;
                        r_bot   <= (r_ca_y < r_cb_y) ? r_ca_y : r_cb_y;
                        r_top   <= (r_ca_y < r_cb_y) ? r_cb_y : r_ca_y;
                        r_moves <= '0;
                        r_state <= S_CODE;
                    end
                end
                S_CODE: begin
                    if ((w_c0 | w_c1) == '0) begin
                        r_vis   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (((w_c0 & w_c1) != '0) ||
                                 (r_moves == C_MOVE_BITS'(C_MAX_MOVES)) ||
                                 (w_dv == '0)) begin
                        r_vis   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_sel   <= w_sel;
                        r_xedge <= w_xedge;
                        r_edge  <= w_edge;
                        r_fa    <= w_fa;
                        r_fb    <= w_fb;
                        r_dv    <= w_dv;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= C_PROD_BITS'(r_fa) * C_PROD_BITS'(r_fb);
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_neg   <= r_prod[C_PROD_BITS-1] ^ r_dv[C_DIFF_BITS-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_sel) begin
                        r_px1 <= r_xedge ? r_edge : w_new_c;
                        r_py1 <= r_xedge ? w_new_c : r_edge;
                    end else begin
                        r_px0 <= r_xedge ? r_edge : w_new_c;
                        r_py0 <= r_xedge ? w_new_c : r_edge;
                    end
                    r_moves <= r_moves + 1'b1;
                    r_state <= S_CODE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid        <= 1'b1;
                        r_out.visible      <= r_vis;
                        r_out.clip_start_x <= r_vis ? r_px0 : '0;
                        r_out.clip_start_y <= r_vis ? r_py0 : '0;
                        r_out.clip_end_x   <= r_vis ? r_px1 : '0;
                        r_out.clip_end_y   <= r_vis ? r_py1 : '0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/csl_chk.sv
// ----------------------------------------------------------------------------
// csl_chk - port-level checks for the line clipper
// Watches the segment and result channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module csl_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input csl_pkg::t_seg_out o_out
);
    import csl_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

    // a rejected segment reports all-zero coordinates
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.visible) |->
        (o_out.clip_start_x == '0 && o_out.clip_start_y == '0 &&
         o_out.clip_end_x == '0 && o_out.clip_end_y == '0))
        else $error("rejected segment with non-zero coordinates");

    // one segment at a time: busy after each accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second segment taken while busy");

    // a fresh result only follows a segment in progress
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a segment in progress");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

endmodule

bind cohen_sutherland_line_clipper_unit csl_chk u_csl_chk (.*);

>>> dv/cohen_sutherland_line_clipper_unit_tb.sv
// ----------------------------------------------------------------------------
// cohen_sutherland_line_clipper_unit_tb - self-checking bench for the clipper
// Drives segments through the valid/stall input channel and predicts each
// clipped result with an independent outcode clipper. Every result
// transaction is compared field by field, in order, against the oldest
// prediction. The window corners are reprogrammed between phases, and the
// sender and receiver idle at random with different weightings per phase.
// ----------------------------------------------------------------------------
module cohen_sutherland_line_clipper_unit_tb;

    import csl_pkg::*;

    localparam int     CLK_HALF       = 5;
    localparam int     RESET_CYCLES   = 8;
    localparam int     DRAIN_CYCLES   = 80;
    localparam int     MAX_GAP        = 40;
    localparam int     TIMEOUT_CYCLES = 1_000_000;
    localparam longint COORD_MIN      = -(longint'(1) <<< (C_COORD_BITS - 1));
    localparam longint COORD_MAX      = (longint'(1) <<< (C_COORD_BITS - 1)) - 1;

    // Clock, reset and DUT-facing signals
    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    t_cfg_idx cfg_index = CFG_CORNER_A_X;
    t_coord   cfg_data  = '0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_seg_in  in_seg    = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_seg_out out_seg;

    // Window as last programmed, and its normalised edges
    t_coord win_ax = C_RST_CORNER_A_X;
    t_coord win_ay = C_RST_CORNER_A_Y;
    t_coord win_bx = C_RST_CORNER_B_X;
    t_coord win_by = C_RST_CORNER_B_Y;
    longint win_left, win_right, win_bot, win_top;

    t_seg_out pending_clips[$];
    int       mismatches    = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    cohen_sutherland_line_clipper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_seg),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_seg)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Clip prediction
    // ------------------------------------------------------------------

    function automatic void refresh_edges();
        longint ax, ay, bx, by;
        ax = win_ax;
        ay = win_ay;
        bx = win_bx;
        by = win_by;
        win_left  = (ax < bx) ? ax : bx;
        win_right = (ax < bx) ? bx : ax;
        win_bot   = (ay < by) ? ay : by;
        win_top   = (ay < by) ? by : ay;
    endfunction

    // Division rounded to nearest, halves away from zero
    function automatic longint round_div(longint n, longint d);
        longint an, ad, q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        if (ad == 0) begin
            return 0;
        end
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_outcode outcode_of(longint x, longint y);
        t_outcode oc;
        oc = '0;
        if (x < win_left)  oc[C_OC_LEFT]   = 1'b1;
        if (y > win_top)   oc[C_OC_TOP]    = 1'b1;
        if (x > win_right) oc[C_OC_RIGHT]  = 1'b1;
        if (y < win_bot)   oc[C_OC_BOTTOM] = 1'b1;
        return oc;
    endfunction

    // Move outside endpoints onto edges until trivially in or out
    function automatic t_seg_out clip_segment(t_seg_in seg);
        longint   x0, y0, x1, y1, ddx, ddy, nx, ny;
        longint   px[2];
        longint   py[2];
        t_outcode oc[2];
        t_outcode code;
        int       moves, p;
        bit       accepted, finished;
        t_seg_out res;
        x0 = seg.start_x;
        y0 = seg.start_y;
        x1 = seg.end_x;
        y1 = seg.end_y;
        ddx = x1 - x0;
        ddy = y1 - y0;
        px[0] = x0;
        py[0] = y0;
        px[1] = x1;
        py[1] = y1;
        oc[0] = outcode_of(x0, y0);
        oc[1] = outcode_of(x1, y1);
        nx = 0;
        ny = 0;
        moves = 0;
        accepted = 1'b0;
        finished = 1'b0;
        while (!finished) begin
            if ((oc[0] | oc[1]) == '0) begin
                accepted = 1'b1;
                finished = 1'b1;
            end else if ((oc[0] & oc[1]) != '0 || moves == C_MAX_MOVES) begin
                finished = 1'b1;
            end else begin
                p = (oc[0] != '0) ? 0 : 1;
                code = oc[p];
                // zero divisor rejects the segment
                if (code[C_OC_LEFT]) begin
                    if (ddx == 0) finished = 1'b1;
                    nx = win_left;
                    ny = y0 + round_div((win_left - x0) * ddy, ddx);
                end else if (code[C_OC_TOP]) begin
                    if (ddy == 0) finished = 1'b1;
                    ny = win_top;
                    nx = x0 + round_div((win_top - y0) * ddx, ddy);
                end else if (code[C_OC_RIGHT]) begin
                    if (ddx == 0) finished = 1'b1;
                    nx = win_right;
                    ny = y0 + round_div((win_right - x0) * ddy, ddx);
                end else begin
                    if (ddy == 0) finished = 1'b1;
                    ny = win_bot;
                    nx = x0 + round_div((win_bot - y0) * ddx, ddy);
                end
                if (!finished) begin
                    px[p] = nx;
                    py[p] = ny;
                    oc[p] = outcode_of(nx, ny);
                    moves++;
                end
            end
        end
        res = '0;
        if (accepted) begin
            res.visible      = 1'b1;
            res.clip_start_x = t_coord'(px[0]);
            res.clip_start_y = t_coord'(py[0]);
            res.clip_end_x   = t_coord'(px[1]);
            res.clip_end_y   = t_coord'(py[1]);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and output-side stalls
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_result(t_seg_out got);
        t_seg_out want;
        if (pending_clips.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding: %h", got));
        end else begin
            want = pending_clips.pop_front();
            if (got.visible !== want.visible)
                report_mismatch($sformatf("visible got %0b want %0b",
                                          got.visible, want.visible));
            if (got.clip_start_x !== want.clip_start_x)
                report_mismatch($sformatf("clip_start_x got %0d want %0d",
                                          got.clip_start_x, want.clip_start_x));
            if (got.clip_start_y !== want.clip_start_y)
                report_mismatch($sformatf("clip_start_y got %0d want %0d",
                                          got.clip_start_y, want.clip_start_y));
            if (got.clip_end_x !== want.clip_end_x)
                report_mismatch($sformatf("clip_end_x got %0d want %0d",
                                          got.clip_end_x, want.clip_end_x));
            if (got.clip_end_y !== want.clip_end_y)
                report_mismatch($sformatf("clip_end_y got %0d want %0d",
                                          got.clip_end_y, want.clip_end_y));
        end
    endtask

    // Values read here are those sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            check_result(out_seg);
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transaction; valid stays high if the next one follows at once
    task automatic send_segment(t_seg_in seg);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_seg   <= seg;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        pending_clips.insert(pending_clips.size(), clip_segment(seg));
    endtask

    // Let every outstanding result arrive, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_clips.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(t_coord ax, t_coord ay, t_coord bx, t_coord by);
        t_cfg_idx idx[4];
        t_coord   val[4];
        wait_drained();
        idx = '{CFG_CORNER_A_X, CFG_CORNER_A_Y, CFG_CORNER_B_X, CFG_CORNER_B_Y};
        val = '{ax, ay, bx, by};
        for (int i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        win_ax = ax;
        win_ay = ay;
        win_bx = bx;
        win_by = by;
        refresh_edges();
    endtask

    function automatic t_seg_in seg_of(int sx, int sy, int ex, int ey);
        t_seg_in seg;
        seg.start_x = t_coord'(sx);
        seg.start_y = t_coord'(sy);
        seg.end_x   = t_coord'(ex);
        seg.end_y   = t_coord'(ey);
        return seg;
    endfunction

    function automatic t_coord pick_coord(longint lo, longint hi);
        if (lo < COORD_MIN) lo = COORD_MIN;
        if (hi > COORD_MAX) hi = COORD_MAX;
        if (lo > hi) lo = hi;
        return t_coord'(lo + longint'($urandom_range(int'(hi - lo), 0)));
    endfunction

    // Mostly segments around the window, some anywhere, some leaving it
    function automatic t_seg_in random_segment();
        t_seg_in seg;
        int      kind;
        longint  mx, my;
        kind = $urandom_range(9);
        mx = (win_right - win_left) / 2 + 64;
        my = (win_top - win_bot) / 2 + 64;
        if (kind < 2) begin
            seg.start_x = t_coord'($urandom);
            seg.start_y = t_coord'($urandom);
            seg.end_x   = t_coord'($urandom);
            seg.end_y   = t_coord'($urandom);
        end else if (kind < 8) begin
            seg.start_x = pick_coord(win_left - mx, win_right + mx);
            seg.start_y = pick_coord(win_bot - my, win_top + my);
            seg.end_x   = pick_coord(win_left - mx, win_right + mx);
            seg.end_y   = pick_coord(win_bot - my, win_top + my);
        end else begin
            seg.start_x = pick_coord(win_left, win_right);
            seg.start_y = pick_coord(win_bot, win_top);
            seg.end_x   = t_coord'($urandom);
            seg.end_y   = t_coord'($urandom);
        end
        return seg;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_segment(random_segment());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window (0,0)-(1079,719): every edge, trivial and clipped rejects, rounding
    task automatic test_default_window();
        send_segment(seg_of(100, 100, 900, 600));      // wholly inside
        send_segment(seg_of(-50, 10, -10, 700));       // both left
        send_segment(seg_of(10, 800, 1000, 900));      // both above
        send_segment(seg_of(1100, 10, 2000, 700));     // both right
        send_segment(seg_of(10, -5, 1000, -900));      // both below
        send_segment(seg_of(-100, 300, 500, 300));     // crosses left edge
        send_segment(seg_of(500, 900, 500, 100));      // crosses top edge
        send_segment(seg_of(1500, 200, 200, 400));     // crosses right edge
        send_segment(seg_of(300, -300, 700, 300));     // crosses bottom edge
        send_segment(seg_of(-200, -100, 1300, 900));   // both ends clipped
        send_segment(seg_of(-100, 600, 200, 1000));    // misses the corner
        send_segment(seg_of(-2048, -2048, 2047, 2047));
        send_segment(seg_of(2047, -2048, -2048, 2047));
        send_segment(seg_of(0, 0, 0, 0));              // point on a corner
        send_segment(seg_of(2047, 2047, 2047, 2047));  // point outside
        send_segment(seg_of(0, 719, 1079, 0));         // ends on the edges
        send_segment(seg_of(-1, 0, 1, 1));             // positive half rounds up
        send_segment(seg_of(-1, 1, 1, 0));             // negative half rounds away
        send_segment(seg_of(-1, -1, -1, -1));
        send_segment(seg_of(2047, 0, -2048, 0));       // horizontal, full span
        send_segment(seg_of(500, -2048, 500, 2047));   // vertical, full span
        send_random(120);
    endtask

    // Window at the coordinate extremes, in both corner orders
    task automatic test_full_window();
        write_window(t_coord'(COORD_MIN), t_coord'(COORD_MIN),
                     t_coord'(COORD_MAX), t_coord'(COORD_MAX));
        send_segment(seg_of(-2048, 2047, 2047, -2048));
        send_segment(seg_of(2047, 2047, -2048, -2048));
        send_random(40);
        write_window(t_coord'(COORD_MAX), t_coord'(COORD_MAX),
                     t_coord'(COORD_MIN), t_coord'(COORD_MIN));
        send_random(40);
    endtask

    task automatic test_swapped_corners();
        write_window(t_coord'(700), t_coord'(500), t_coord'(-300), t_coord'(-250));
        send_random(120);
    endtask

    // Zero-width windows: a point, a column and a row on the top boundary
    task automatic test_degenerate_windows();
        write_window(t_coord'(37), t_coord'(-12), t_coord'(37), t_coord'(-12));
        send_segment(seg_of(0, -12, 74, -12));
        send_segment(seg_of(37, -100, 37, 100));
        send_random(40);
        write_window(t_coord'(-5), t_coord'(COORD_MIN), t_coord'(-5), t_coord'(COORD_MAX));
        send_random(40);
        write_window(t_coord'(COORD_MIN), t_coord'(COORD_MAX),
                     t_coord'(COORD_MAX), t_coord'(COORD_MAX));
        send_random(20);
    endtask

    task automatic test_random_windows();
        longint cx, cy, hx, hy;
        repeat (6) begin
            if ($urandom_range(1) == 0) begin
                write_window(t_coord'($urandom), t_coord'($urandom),
                             t_coord'($urandom), t_coord'($urandom));
            end else begin
                cx = pick_coord(COORD_MIN, COORD_MAX);
                cy = pick_coord(COORD_MIN, COORD_MAX);
                hx = $urandom_range(300);
                hy = $urandom_range(300);
                write_window(pick_coord(cx - hx, cx - hx), pick_coord(cy + hy, cy + hy),
                             pick_coord(cx + hx, cx + hx), pick_coord(cy - hy, cy - hy));
            end
            send_random(30);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        refresh_edges();
        send_idle_pct = 16;
        recv_idle_pct = 47;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_window();
        test_full_window();

        send_idle_pct = 47;
        recv_idle_pct = 16;
        test_swapped_corners();
        test_degenerate_windows();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_windows();

        wait_drained();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/csl_pkg.sv
rtl/csl_div.sv
rtl/cohen_sutherland_line_clipper_unit.sv
rtl/csl_chk.sv
dv/cohen_sutherland_line_clipper_unit_tb.sv
